>>> src/ptb_pkg.sv
package ptb_pkg;

  localparam int MAX_LEN_DEF  = 4096;
  localparam int ALPHABET_DEF = 10;
  localparam int FW           = 13;
  localparam int SW           = 4;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_WALK_RD  = 4'd2;
  localparam logic [3:0] OP_WALK_POS = 4'd3;
  localparam logic [3:0] OP_WALK_TST = 4'd4;
  localparam logic [3:0] OP_CH_RD    = 4'd5;
  localparam logic [3:0] OP_CH_META  = 4'd6;
  localparam logic [3:0] OP_CH_EVAL  = 4'd7;
  localparam logic [3:0] OP_OUT_OLD  = 4'd8;
  localparam logic [3:0] OP_CREATE   = 4'd9;
  localparam logic [3:0] OP_CLEAR    = 4'd10;

  typedef struct packed {
    logic op3;
  } unused_t;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic ext;
    logic child_ok;
    logic mode1;
    logic clr_done;
  } stat_t;

endpackage

>>> src/ptb_ram.sv
module ptb_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/ptb_ctrl.sv
module ptb_ctrl import ptb_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WA   = 4'd1;
  localparam logic [3:0] S_WB   = 4'd2;
  localparam logic [3:0] S_WC   = 4'd3;
  localparam logic [3:0] S_CA   = 4'd4;
  localparam logic [3:0] S_CB   = 4'd5;
  localparam logic [3:0] S_CC   = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_CLR  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       create_r, create_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    create_nxt = create_r;
    cmd.op     = OP_NONE;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          if (!stat.drop) state_nxt = S_WA;
        end
      end
      S_WA: begin
        cmd.op    = OP_WALK_RD;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.op    = OP_WALK_POS;
        state_nxt = S_WC;
      end
      S_WC: begin
        cmd.op    = OP_WALK_TST;
        state_nxt = stat.ext ? S_CA : S_WA;
      end
      S_CA: begin
        cmd.op    = OP_CH_RD;
        state_nxt = S_CB;
      end
      S_CB: begin
        cmd.op    = OP_CH_META;
        state_nxt = S_CC;
      end
      S_CC: begin
        cmd.op = OP_CH_EVAL;
        if (stat.mode1) begin
          create_nxt = 1'b1;
          state_nxt  = S_FIN;
        end else if (stat.child_ok) begin
          create_nxt = 1'b0;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_WA;
        end
      end
      S_FIN: begin
        cmd.op    = create_r ? OP_CREATE : OP_OUT_OLD;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      create_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      create_r <= create_nxt;
    end
  end
endmodule

>>> src/ptb_dp.sv
module ptb_dp import ptb_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  input  logic [SW-1:0] in_symbol,
  input  logic          in_restart,
  output stat_t         stat,
  output logic          out_valid,
  output logic [FW-1:0] out_node_index,
  output logic [FW-1:0] out_suffix_len,
  output logic [FW-1:0] out_suffix_count,
  output logic          out_is_new,
  output logic          out_full_res
);
  localparam int NCAP = MAX_LEN + 2;
  localparam int NW   = $clog2(NCAP);
  localparam int LW   = $clog2(MAX_LEN + 1);
  localparam int PW   = LW + 2;
  localparam int SD   = MAX_LEN + 1;
  localparam int SAW  = $clog2(SD);
  localparam int CD   = NCAP * ALPHABET;
  localparam int CW   = $clog2(CD);

  logic [LW-1:0] slen_r;
  logic [NW-1:0] last_r, ncnt_r, x_r, now_r, w_r, c_r, f_r;
  logic [SW-1:0] t_r;
  logic          mode1_r;
  logic signed [PW-1:0] lenx_r, lennow_r, pos_r;
  logic [NW-1:0] failx_r, failnow_r;
  logic [CW-1:0] clr_r;

  logic          out_valid_r, out_is_new_r, out_full_r;
  logic [FW-1:0] out_node_r, out_len_r, out_cnt_r;

  logic          sym_we;
  logic [SAW-1:0] sym_raddr;
  logic [SW-1:0] sym_rd;
  logic          node_we;
  logic [NW-1:0] len_raddr, fail_raddr, dep_raddr, par_raddr;
  logic [LW-1:0] len_rd;
  logic [NW-1:0] fail_rd, dep_rd, par_rd, ch_rd;
  logic [SW-1:0] esym_rd;
  logic [CW-1:0] ch_raddr, ch_waddr;
  logic          clr_on, ch_we;
  logic [CW-1:0] ch_wa;
  logic [NW-1:0] ch_wd;

  logic          restart_eff, bad_sym, full_now;
  logic [LW-1:0] slen_eff;
  logic [LW:0]   slen_inc;
  logic signed [PW-1:0] lenx_now, pos_now;
  logic [NW-1:0] failx_now, c_now;
  logic          ok_now, ext_now;
  logic signed [PW-1:0] newlen;
  logic [NW-1:0] newdep;

  assign restart_eff = in_restart;
  assign slen_eff    = restart_eff ? '0 : slen_r;
  assign bad_sym     = (32'(in_symbol) >= ALPHABET);
  assign full_now    = (32'(slen_eff) >= MAX_LEN);
  assign slen_inc    = {1'b0, slen_eff} + 1'b1;

  assign lenx_now  = (x_r == NW'(0)) ? PW'(0) :
                     (x_r == NW'(1)) ? -PW'(1) : PW'(signed'({1'b0, len_rd}));
  assign failx_now = (x_r == NW'(0)) ? NW'(1) :
                     (x_r == NW'(1)) ? NW'(0) : fail_rd;
  assign pos_now   = PW'(signed'({1'b0, slen_r})) - lenx_now - PW'(1);
  assign ext_now   = (x_r == NW'(1)) ||
                     ((pos_r >= PW'(1)) && (pos_r <= PW'(signed'({1'b0, slen_r})))
                      && (sym_rd == t_r));
  assign c_now     = ch_rd;
  assign ok_now    = (c_r >= NW'(2)) && (c_r < ncnt_r) && (par_rd == w_r) &&
                     (esym_rd == t_r);
  assign newlen    = lennow_r + PW'(2);
  assign newdep    = (f_r < NW'(2)) ? NW'(1) : dep_rd + NW'(1);

  assign stat.drop     = bad_sym || full_now;
  assign stat.ext      = ext_now;
  assign stat.child_ok = ok_now;
  assign stat.mode1    = mode1_r;
  assign stat.clr_done = (clr_r == CW'(CD - 1));

  assign sym_we    = (cmd.op == OP_LOAD) && !bad_sym && !full_now;
  assign node_we   = (cmd.op == OP_CREATE);
  assign clr_on    = (cmd.op == OP_CLEAR);
  assign sym_raddr = SAW'(pos_now);
  assign fail_raddr = x_r;
  assign len_raddr = (cmd.op == OP_CH_EVAL) ? c_r : x_r;
  assign dep_raddr = (cmd.op == OP_CH_EVAL && mode1_r && !ok_now) ? NW'(0) : c_r;
  assign par_raddr = c_now;
  assign ch_raddr  = CW'(w_r) * CW'(ALPHABET) + CW'(t_r);
  assign ch_waddr  = CW'(now_r) * CW'(ALPHABET) + CW'(t_r);
  assign ch_we     = node_we || clr_on;
  assign ch_wa     = clr_on ? clr_r : ch_waddr;
  assign ch_wd     = clr_on ? '0 : ncnt_r;

  ptb_ram #(.W(SW), .D(SD)) u_sym (
    .clk(clk), .we(sym_we), .waddr(SAW'(slen_inc)), .wdata(in_symbol),
    .raddr(sym_raddr), .rdata(sym_rd));
  ptb_ram #(.W(LW), .D(NCAP)) u_len (
    .clk(clk), .we(node_we), .waddr(ncnt_r), .wdata(LW'(newlen)),
    .raddr(len_raddr), .rdata(len_rd));
  ptb_ram #(.W(NW), .D(NCAP)) u_fail (
    .clk(clk), .we(node_we), .waddr(ncnt_r), .wdata(f_r),
    .raddr(fail_raddr), .rdata(fail_rd));
  ptb_ram #(.W(NW), .D(NCAP)) u_dep (
    .clk(clk), .we(node_we), .waddr(ncnt_r), .wdata(newdep),
    .raddr(dep_raddr), .rdata(dep_rd));
  ptb_ram #(.W(NW), .D(NCAP)) u_par (
    .clk(clk), .we(node_we), .waddr(ncnt_r), .wdata(now_r),
    .raddr(par_raddr), .rdata(par_rd));
  ptb_ram #(.W(SW), .D(NCAP)) u_esym (
    .clk(clk), .we(node_we), .waddr(ncnt_r), .wdata(t_r),
    .raddr(par_raddr), .rdata(esym_rd));
  ptb_ram #(.W(NW), .D(CD)) u_child (
    .clk(clk), .we(ch_we), .waddr(ch_wa), .wdata(ch_wd),
    .raddr(ch_raddr), .rdata(ch_rd));

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        t_r <= in_symbol;
        x_r <= restart_eff ? NW'(0) : last_r;
      end
      OP_WALK_POS: begin
        lenx_r  <= lenx_now;
        failx_r <= failx_now;
        pos_r   <= pos_now;
      end
      OP_WALK_TST: begin
        if (ext_now) begin
          w_r <= x_r;
          if (!mode1_r) begin
            now_r     <= x_r;
            lennow_r  <= lenx_r;
            failnow_r <= failx_r;
          end
        end else begin
          x_r <= failx_r;
        end
      end
      OP_CH_META: c_r <= c_now;
      OP_CH_EVAL: begin
        f_r <= ok_now ? c_r : NW'(0);
        if (!mode1_r && !ok_now) x_r <= failnow_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slen_r      <= '0;
      last_r      <= '0;
      ncnt_r      <= NW'(2);
      mode1_r     <= 1'b0;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (cmd.op)
        OP_CLEAR: clr_r <= clr_r + CW'(1);
        OP_LOAD: begin
          mode1_r <= 1'b0;
          if (restart_eff) begin
            last_r <= '0;
            ncnt_r <= NW'(2);
          end
          if (bad_sym || full_now) begin
            slen_r       <= slen_eff;
            out_valid_r  <= 1'b1;
            out_node_r   <= '0;
            out_len_r    <= '0;
            out_cnt_r    <= '0;
            out_is_new_r <= 1'b0;
            out_full_r   <= !bad_sym;
          end else begin
            slen_r <= LW'(slen_inc);
          end
        end
        OP_CH_EVAL: begin
          if (!mode1_r && !ok_now) mode1_r <= 1'b1;
        end
        OP_OUT_OLD: begin
          last_r       <= c_r;
          out_valid_r  <= 1'b1;
          out_node_r   <= FW'(c_r);
          out_len_r    <= FW'(len_rd);
          out_cnt_r    <= FW'(dep_rd);
          out_is_new_r <= 1'b0;
          out_full_r   <= 1'b0;
        end
        OP_CREATE: begin
          last_r       <= ncnt_r;
          ncnt_r       <= ncnt_r + NW'(1);
          out_valid_r  <= 1'b1;
          out_node_r   <= FW'(ncnt_r);
          out_len_r    <= FW'(newlen);
          out_cnt_r    <= FW'(newdep);
          out_is_new_r <= 1'b1;
          out_full_r   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_node_index   = out_node_r;
  assign out_suffix_len   = out_len_r;
  assign out_suffix_count = out_cnt_r;
  assign out_is_new       = out_is_new_r;
  assign out_full_res     = out_full_r;
endmodule

>>> src/palindromic_tree_builder.sv
// A dropped symbol is answered from idle without a walk; otherwise each fail-link test reads
// the length and stored symbol and compares, each child lookup reads and checks the child,
// and a finish step emits the result; a new node walks the fail links a second time.
// One request at a time: the next is taken in the cycle out_valid pulses; no receiver stall.
// Reset (rst_n low, synchronous): empty string, two roots; then busy stays high for a
// pass that zeroes all (MAX_LEN+2)*ALPHABET entries of the child table.
module palindromic_tree_builder import ptb_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [SW-1:0] in_symbol,
  input  logic          in_restart,
  output logic          out_valid,
  output logic [FW-1:0] out_node_index,
  output logic [FW-1:0] out_suffix_len,
  output logic [FW-1:0] out_suffix_count,
  output logic          out_is_new,
  output logic          out_full_res
);
  cmd_t  cmd;
  stat_t stat;

  ptb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy));

  ptb_dp #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_symbol(in_symbol),
    .in_restart(in_restart), .stat(stat), .out_valid(out_valid),
    .out_node_index(out_node_index), .out_suffix_len(out_suffix_len),
    .out_suffix_count(out_suffix_count), .out_is_new(out_is_new),
    .out_full_res(out_full_res));
endmodule

>>> tb/eertree_checker.sv
module eertree_checker import ptb_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  logic [SW-1:0] in_symbol,
  input  logic          in_restart,
  input  logic          out_valid,
  input  logic [FW-1:0] out_node_index,
  input  logic [FW-1:0] out_suffix_len,
  input  logic [FW-1:0] out_suffix_count,
  input  logic          out_is_new,
  input  logic          out_full_res,
  output int            errors,
  output int            pending,
  output int            checked,
  output int            created_cnt,
  output int            full_cnt
);

  localparam int NODE_CAP = MAX_LEN + 2;

  typedef struct {
    logic [FW-1:0] node;
    logic [FW-1:0] len;
    logic [FW-1:0] cnt;
    logic          is_new;
    logic          full;
  } suffix_info_t;

  logic [SW-1:0] text_mem [0:MAX_LEN];
  int pal_len [NODE_CAP];
  int pal_link [NODE_CAP];
  int pal_depth [NODE_CAP];
  int pal_child [NODE_CAP][ALPHABET];
  int text_len, longest_node, node_total;
  suffix_info_t suffix_q[$];

  function automatic int add_node(int len);
    int id;
    id = node_total;
    for (int a = 0; a < ALPHABET; a++) pal_child[id][a] = 0;
    pal_link[id] = 0;
    pal_depth[id] = 0;
    pal_len[id] = len;
    node_total = id + 1;
    return id;
  endfunction

  function automatic void clear_tree();
    int dummy;
    node_total = 0;
    text_len = 0;
    longest_node = 0;
    dummy = add_node(0);
    dummy = add_node(-1);
    pal_link[0] = 1;
    pal_link[1] = 0;
  endfunction

  function automatic bit can_wrap(int x);
    int pos;
    pos = text_len - pal_len[x] - 1;
    if (pos <= 0 || pos > text_len) return 0;
    return text_mem[pos] == text_mem[text_len];
  endfunction

  function automatic int follow_links(int x);
    while (x != 1 && !can_wrap(x)) x = pal_link[x];
    return x;
  endfunction

  function automatic suffix_info_t append_symbol(logic [SW-1:0] sym, logic rs);
    suffix_info_t r;
    int cur, id, f, node;
    r = '{default: '0};
    if (rs) clear_tree();
    if (sym >= ALPHABET) return r;
    if (text_len >= MAX_LEN) begin
      r.full = 1'b1;
      return r;
    end
    text_len++;
    text_mem[text_len] = sym;
    cur = follow_links(longest_node);
    if (pal_child[cur][sym] == 0) begin
      id = add_node(pal_len[cur] + 2);
      f = pal_child[follow_links(pal_link[cur])][sym];
      pal_link[id] = f;
      pal_depth[id] = pal_depth[f] + 1;
      pal_child[cur][sym] = id;
      r.is_new = 1'b1;
    end
    node = pal_child[cur][sym];
    longest_node = node;
    r.node = node[FW-1:0];
    r.len = pal_len[node][FW-1:0];
    r.cnt = pal_depth[node][FW-1:0];
    return r;
  endfunction

  initial begin
    errors = 0;
    checked = 0;
    created_cnt = 0;
    full_cnt = 0;
    clear_tree();
  end

  assign pending = suffix_q.size();

  always @(posedge clk) begin
    suffix_info_t e;
    if (!rst_n) begin
      clear_tree();
      suffix_q.delete();
    end else begin
      if (out_valid) begin
        if (suffix_q.size() == 0) begin
          $display("%0t: unexpected result node=%0d", $time, out_node_index);
          errors <= errors + 1;
        end else begin
          e = suffix_q.pop_front();
          checked <= checked + 1;
          if (out_node_index !== e.node || out_suffix_len !== e.len ||
              out_suffix_count !== e.cnt || out_is_new !== e.is_new ||
              out_full_res !== e.full) begin
            $display("%0t: mismatch exp node=%0d len=%0d cnt=%0d new=%0d full=%0d",
                     $time, e.node, e.len, e.cnt, e.is_new, e.full);
            $display("%0t:          got node=%0d len=%0d cnt=%0d new=%0d full=%0d",
                     $time, out_node_index, out_suffix_len, out_suffix_count,
                     out_is_new, out_full_res);
            errors <= errors + 1;
          end
          if (e.is_new) created_cnt <= created_cnt + 1;
          if (e.full) full_cnt <= full_cnt + 1;
        end
      end
      if (start && !busy) suffix_q.push_back(append_symbol(in_symbol, in_restart));
    end
  end

endmodule

>>> tb/testbench.sv
module testbench;
  import ptb_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [SW-1:0] in_symbol = '0;
  logic          in_restart = 1'b0;
  logic          out_valid;
  logic [FW-1:0] out_node_index, out_suffix_len, out_suffix_count;
  logic          out_is_new, out_full_res;
  int            errors, pending, checked, created_cnt, full_cnt;
  int            cycles = 0;
  int            burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  palindromic_tree_builder dut (.*);

  eertree_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests pending", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // one request; holds start until accepted, then an optional gap
  task automatic send_req(logic [SW-1:0] sym, logic rs, bit bursty);
    int gap;
    start <= 1'b1;
    in_symbol <= sym;
    in_restart <= rs;
    do @(posedge clk); while (busy);
    gap = 0;
    if (bursty) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [SW-1:0] rand_symbol();
    case ($urandom_range(0, 9))
      0:       return SW'($urandom_range(10, 15));
      1, 2, 3: return SW'($urandom_range(0, 9));
      default: return SW'($urandom_range(0, 2));
    endcase
  endfunction

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: odd/even palindromes, out-of-range, restart cases
    send_req(4'd9, 1'b0, 1'b0);
    send_req(4'd9, 1'b0, 1'b0);
    send_req(4'd0, 1'b0, 1'b0);
    send_req(4'd9, 1'b0, 1'b0);
    send_req(4'd9, 1'b0, 1'b0);
    send_req(4'd10, 1'b0, 1'b0);
    send_req(4'd15, 1'b0, 1'b0);
    send_req(4'd5, 1'b1, 1'b0);
    send_req(4'd5, 1'b0, 1'b0);
    send_req(4'd12, 1'b1, 1'b0);
    send_req(4'd3, 1'b0, 1'b0);
    send_req(4'd4, 1'b0, 1'b0);
    send_req(4'd3, 1'b0, 1'b0);
    send_req(4'd3, 1'b1, 1'b0);
    send_req(4'd7, 1'b1, 1'b0);
    send_req(4'd7, 1'b0, 1'b0);
    send_req(4'd2, 1'b0, 1'b0);
    send_req(4'd11, 1'b0, 1'b0);
    send_req(4'd14, 1'b1, 1'b0);
    send_req(4'd1, 1'b0, 1'b0);

    // random: long well-formed runs with occasional restarts and noise
    n = 0;
    while (n < 1030) begin
      if ($urandom_range(0, 5) == 0)
        send_req(SW'($urandom_range(0, 9)), $urandom_range(0, 60) == 0, 1'b1);
      else
        send_req(rand_symbol(), $urandom_range(0, 80) == 0, 1'b1);
      n++;
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("checked %0d results: %0d new nodes, %0d full-store drops",
             checked, created_cnt, full_cnt);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
